// ===== hw/rtl/lbnr_pkg.sv =====
// ----------------------------------------------------------------------------
// Letterbox resize map package
// Shared constants, register indexes and types for the letterbox nearest
// neighbor resize map.
// ----------------------------------------------------------------------------
package lbnr_pkg;

  // Frame size of the detector input.
  localparam int OutWidthDef  = 640;
  localparam int OutHeightDef = 640;

  // Configuration register port.
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 20;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SCREEN_W  = 3'd0,
    REG_SCREEN_H  = 3'd1,
    REG_RESIZED_W = 3'd2,
    REG_RESIZED_H = 3'd3,
    REG_PAD_X     = 3'd4,
    REG_PAD_Y     = 3'd5,
    REG_INV_SCALE = 3'd6
  } reg_idx_e;

  // Item operation codes.
  typedef enum logic {
    OP_MAP     = 1'b0,
    OP_CONVERT = 1'b1
  } op_e;

  // Field widths.
  localparam int ScreenW  = 14;
  localparam int SizeW    = 10;
  localparam int PadW     = 9;
  localparam int ScaleW   = 20;
  localparam int ScaleFrac = 16;
  localparam int DstW     = 10;
  localparam int SrcW     = 13;
  localparam int IndexW   = 26;
  localparam int ByteW    = 8;
  localparam int NormW    = 16;
  localparam int FrameCmpW = 13;
  localparam int ProdW    = DstW + ScaleW;
  localparam int ScaledW  = ProdW - ScaleFrac;

  // Register reset values.
  localparam logic [ScreenW-1:0] ScreenWRst  = 14'd1920;
  localparam logic [ScreenW-1:0] ScreenHRst  = 14'd1080;
  localparam logic [SizeW-1:0]   ResizedWRst = 10'd640;
  localparam logic [SizeW-1:0]   ResizedHRst = 10'd360;
  localparam logic [PadW-1:0]    PadXRst     = 9'd0;
  localparam logic [PadW-1:0]    PadYRst     = 9'd140;
  localparam logic [ScaleW-1:0]  InvScaleRst = 20'd196608;

  // Gray value used for padding pixels.
  localparam logic [ByteW-1:0] PadValue = 8'd114;

  // Largest source coordinate the output fields can carry.
  localparam logic [SrcW-1:0] SrcMax = '1;

  // Stage one: window check done, offsets from the window origin.
  typedef struct packed {
    op_e                    op;
    logic                   ok;
    logic [DstW-1:0]        ox;
    logic [DstW-1:0]        oy;
    logic [ByteW-1:0]       r;
    logic [ByteW-1:0]       g;
    logic [ByteW-1:0]       b;
  } s1_t;

  // Stage two: offsets scaled to source pixels, not yet clamped.
  typedef struct packed {
    op_e                    op;
    logic                   ok;
    logic [ScaledW-1:0]     px;
    logic [ScaledW-1:0]     py;
    logic [ByteW-1:0]       r;
    logic [ByteW-1:0]       g;
    logic [ByteW-1:0]       b;
  } s2_t;

  // Stage three: clamped source coordinates.
  typedef struct packed {
    op_e                    op;
    logic                   ok;
    logic [SrcW-1:0]        sx;
    logic [SrcW-1:0]        sy;
    logic [ByteW-1:0]       r;
    logic [ByteW-1:0]       g;
    logic [ByteW-1:0]       b;
  } s3_t;

endpackage

// ===== hw/rtl/letterbox_nearest_resize_map.sv =====
// Throughput: one item per cycle while the output is not stalled. An item
// passes in order through four registered stages (window check, scale
// multiply, clamp, index multiply-add) on its way to the output port.
// Each stage holds its item while the stage after it is full and stalled.
// Reset (rst_ni low, asynchronous) empties the pipeline and loads the
// configuration registers with their default 1920x1080 to 640x360 setup.
// ----------------------------------------------------------------------------
// Letterbox nearest neighbor resize map
// Maps detector frame positions to nearest source pixels and converts pixel
// bytes to Q0.16 RGB values.
// ----------------------------------------------------------------------------
module letterbox_nearest_resize_map #(
  parameter int OUT_WIDTH  = lbnr_pkg::OutWidthDef,
  parameter int OUT_HEIGHT = lbnr_pkg::OutHeightDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write port.
  input  logic                            cfg_we_i,
  input  logic [lbnr_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [lbnr_pkg::CfgDataW-1:0]   cfg_data_i,
  // Input channel.
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            op_i,
  input  logic [lbnr_pkg::DstW-1:0]       dst_x_i,
  input  logic [lbnr_pkg::DstW-1:0]       dst_y_i,
  input  logic [lbnr_pkg::ByteW-1:0]      blue_i,
  input  logic [lbnr_pkg::ByteW-1:0]      green_i,
  input  logic [lbnr_pkg::ByteW-1:0]      red_i,
  input  logic                            pad_i,
  // Output channel.
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            inside_res_o,
  output logic [lbnr_pkg::SrcW-1:0]       src_x_o,
  output logic [lbnr_pkg::SrcW-1:0]       src_y_o,
  output logic [lbnr_pkg::IndexW-1:0]     src_index_o,
  output logic [lbnr_pkg::NormW-1:0]      red_norm_o,
  output logic [lbnr_pkg::NormW-1:0]      green_norm_o,
  output logic [lbnr_pkg::NormW-1:0]      blue_norm_o
);
  import lbnr_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers, read directly by every stage. The user must
  // change them only while the pipeline is empty; the block does not enforce it.
  // --------------------------------------------------------------------------
  logic [ScreenW-1:0] screen_w_q, screen_h_q;
  logic [SizeW-1:0]   resized_w_q, resized_h_q;
  logic [PadW-1:0]    pad_x_q, pad_y_q;
  logic [ScaleW-1:0]  inv_scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_w_q  <= ScreenWRst;
      screen_h_q  <= ScreenHRst;
      resized_w_q <= ResizedWRst;
      resized_h_q <= ResizedHRst;
      pad_x_q     <= PadXRst;
      pad_y_q     <= PadYRst;
      inv_scale_q <= InvScaleRst;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_SCREEN_W:  screen_w_q  <= cfg_data_i[ScreenW-1:0];
        REG_SCREEN_H:  screen_h_q  <= cfg_data_i[ScreenW-1:0];
        REG_RESIZED_W: resized_w_q <= cfg_data_i[SizeW-1:0];
        REG_RESIZED_H: resized_h_q <= cfg_data_i[SizeW-1:0];
        REG_PAD_X:     pad_x_q     <= cfg_data_i[PadW-1:0];
        REG_PAD_Y:     pad_y_q     <= cfg_data_i[PadW-1:0];
        REG_INV_SCALE: inv_scale_q <= cfg_data_i[ScaleW-1:0];
        default: ;  // Unused index: the write is dropped.
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control. A stage takes a new item when it is empty or when
  // its current item moves on in the same cycle, so bubbles are squeezed out
  // and a stall at the output holds every item with no empty stage ahead of it.
  // --------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4_q || out_ready_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign in_ready_o  = rdy1;
  assign out_valid_o = v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: window check and offsets. A position counts as inside only when
  // it is inside the frame and inside the scaled window on both axes. Padding
  // pixels take the fixed gray value here.
  // --------------------------------------------------------------------------
  s1_t s1_d, s1_q;
  logic [DstW-1:0] ox, oy;
  logic okx, oky;

  always_comb begin
    ox  = dst_x_i - DstW'(pad_x_q);
    oy  = dst_y_i - DstW'(pad_y_q);
    okx = (FrameCmpW'(dst_x_i) < FrameCmpW'(OUT_WIDTH)) &&
          (dst_x_i >= DstW'(pad_x_q)) && (ox < resized_w_q);
    oky = (FrameCmpW'(dst_y_i) < FrameCmpW'(OUT_HEIGHT)) &&
          (dst_y_i >= DstW'(pad_y_q)) && (oy < resized_h_q);

    s1_d.op = op_e'(op_i);
    s1_d.ok = okx && oky;
    s1_d.ox = ox;
    s1_d.oy = oy;
    if (pad_i) begin
      s1_d.r = PadValue;
      s1_d.g = PadValue;
      s1_d.b = PadValue;
    end else begin
      s1_d.r = red_i;
      s1_d.g = green_i;
      s1_d.b = blue_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) s1_q <= s1_d;
  end

  // --------------------------------------------------------------------------
  // Stage 2: offset times the Q4.16 inverse scale, fraction dropped (floor).
  // --------------------------------------------------------------------------
  s2_t s2_d, s2_q;
  logic [ProdW-1:0] prod_x, prod_y;

  always_comb begin
    prod_x  = ProdW'(s1_q.ox) * ProdW'(inv_scale_q);
    prod_y  = ProdW'(s1_q.oy) * ProdW'(inv_scale_q);
    s2_d.op = s1_q.op;
    s2_d.ok = s1_q.ok;
    s2_d.px = prod_x[ProdW-1:ScaleFrac];
    s2_d.py = prod_y[ProdW-1:ScaleFrac];
    s2_d.r  = s1_q.r;
    s2_d.g  = s1_q.g;
    s2_d.b  = s1_q.b;
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) s2_q <= s2_d;
  end

  // --------------------------------------------------------------------------
  // Stage 3: clamp to the last screen pixel, and to the largest value the
  // output field holds. An empty screen clamps to zero.
  // --------------------------------------------------------------------------
  s3_t s3_d, s3_q;
  logic [ScreenW-1:0] wm1, hm1;
  logic [SrcW-1:0]    lim_x, lim_y;

  always_comb begin
    wm1 = screen_w_q - ScreenW'(1);
    hm1 = screen_h_q - ScreenW'(1);
    if (screen_w_q == '0)                 lim_x = '0;
    else if (wm1 > ScreenW'(SrcMax))      lim_x = SrcMax;
    else                                  lim_x = wm1[SrcW-1:0];
    if (screen_h_q == '0)                 lim_y = '0;
    else if (hm1 > ScreenW'(SrcMax))      lim_y = SrcMax;
    else                                  lim_y = hm1[SrcW-1:0];

    s3_d.op = s2_q.op;
    s3_d.ok = s2_q.ok;
    s3_d.sx = (s2_q.px > ScaledW'(lim_x)) ? lim_x : s2_q.px[SrcW-1:0];
    s3_d.sy = (s2_q.py > ScaledW'(lim_y)) ? lim_y : s2_q.py[SrcW-1:0];
    s3_d.r  = s2_q.r;
    s3_d.g  = s2_q.g;
    s3_d.b  = s2_q.b;
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) s3_q <= s3_d;
  end

  // --------------------------------------------------------------------------
  // Stage 4: source index as row times screen width plus column, kept to the
  // field width. Fields of the other operation, and all map fields outside
  // the window, read as zero. v*257 is the byte repeated in both halves.
  // --------------------------------------------------------------------------
  logic               inside_d, inside_q;
  logic [SrcW-1:0]    src_x_d, src_x_q, src_y_d, src_y_q;
  logic [IndexW-1:0]  index_d, index_q;
  logic [NormW-1:0]   rn_d, rn_q, gn_d, gn_q, bn_d, bn_q;

  always_comb begin
    inside_d = (s3_q.op == OP_MAP) && s3_q.ok;
    src_x_d  = inside_d ? s3_q.sx : '0;
    src_y_d  = inside_d ? s3_q.sy : '0;
    index_d  = inside_d ?
               (IndexW'(s3_q.sy) * IndexW'(screen_w_q) + IndexW'(s3_q.sx)) : '0;
    if (s3_q.op == OP_CONVERT) begin
      rn_d = {s3_q.r, s3_q.r};
      gn_d = {s3_q.g, s3_q.g};
      bn_d = {s3_q.b, s3_q.b};
    end else begin
      rn_d = '0;
      gn_d = '0;
      bn_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && v3_q) begin
      inside_q <= inside_d;
      src_x_q  <= src_x_d;
      src_y_q  <= src_y_d;
      index_q  <= index_d;
      rn_q     <= rn_d;
      gn_q     <= gn_d;
      bn_q     <= bn_d;
    end
  end

  assign inside_res_o = inside_q;
  assign src_x_o      = src_x_q;
  assign src_y_o      = src_y_q;
  assign src_index_o  = index_q;
  assign red_norm_o   = rn_q;
  assign green_norm_o = gn_q;
  assign blue_norm_o  = bn_q;

endmodule

// ===== hw/rtl/lbnr_checker.sv =====
// ----------------------------------------------------------------------------
// Letterbox resize map checker
// Port-level checks on results of the letterbox resize map.
// ----------------------------------------------------------------------------
module lbnr_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic                            inside_res_o,
  input logic [lbnr_pkg::SrcW-1:0]       src_x_o,
  input logic [lbnr_pkg::SrcW-1:0]       src_y_o,
  input logic [lbnr_pkg::IndexW-1:0]     src_index_o,
  input logic [lbnr_pkg::NormW-1:0]      red_norm_o,
  input logic [lbnr_pkg::NormW-1:0]      green_norm_o,
  input logic [lbnr_pkg::NormW-1:0]      blue_norm_o
);
  import lbnr_pkg::*;

  // A stalled result stays offered with the same payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(src_index_o) && $stable(inside_res_o) &&
       $stable(red_norm_o)))
    else $error("result changed while stalled");

  // A position outside the window carries no source coordinates.
  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !inside_res_o) |->
      (src_x_o == '0 && src_y_o == '0 && src_index_o == '0))
    else $error("outside position carries source fields");

  // A mapped result never carries color values.
  a_map_no_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && inside_res_o) |->
      (red_norm_o == '0 && green_norm_o == '0 && blue_norm_o == '0))
    else $error("map result carries color values");

  // Byte times 257 repeats the byte in both halves.
  a_norm_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (red_norm_o[15:8] == red_norm_o[7:0] &&
       green_norm_o[15:8] == green_norm_o[7:0] &&
       blue_norm_o[15:8] == blue_norm_o[7:0]))
    else $error("normalized value is not byte times 257");

endmodule

bind letterbox_nearest_resize_map lbnr_checker u_lbnr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .inside_res_o (inside_res_o),
  .src_x_o      (src_x_o),
  .src_y_o      (src_y_o),
  .src_index_o  (src_index_o),
  .red_norm_o   (red_norm_o),
  .green_norm_o (green_norm_o),
  .blue_norm_o  (blue_norm_o)
);

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// Letterbox resize map testbench
// Drives map and convert transfers through the letterbox nearest neighbor
// resize map under several register setups, predicts every result from a
// behavioral copy of the mapping and the color normalization, and compares
// each output transfer field by field while both sides idle at random.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lbnr_pkg::*;

  localparam int FrameWidth  = OutWidthDef;
  localparam int FrameHeight = OutHeightDef;
  // Far above the slowest legal run of about a thousand transfers.
  localparam int CycleLimit  = 200000;
  localparam int PhaseItems  = 170;
  localparam int RandPhases  = 6;
  localparam int IdlePercent = 38;
  localparam int NormScale   = 257;

  // One input transfer, as the sender holds it on the ports.
  typedef struct packed {
    op_e               op;
    logic [DstW-1:0]   dst_x;
    logic [DstW-1:0]   dst_y;
    logic [ByteW-1:0]  blue;
    logic [ByteW-1:0]  green;
    logic [ByteW-1:0]  red;
    logic              pad;
  } pixel_req_t;

  // One output transfer.
  typedef struct packed {
    logic              inside_res;
    logic [SrcW-1:0]   src_x;
    logic [SrcW-1:0]   src_y;
    logic [IndexW-1:0] src_index;
    logic [NormW-1:0]  red_norm;
    logic [NormW-1:0]  green_norm;
    logic [NormW-1:0]  blue_norm;
  } pixel_res_t;

  // Our own copy of the configuration registers.
  typedef struct packed {
    logic [ScreenW-1:0] screen_w;
    logic [ScreenW-1:0] screen_h;
    logic [SizeW-1:0]   resized_w;
    logic [SizeW-1:0]   resized_h;
    logic [PadW-1:0]    pad_x;
    logic [PadW-1:0]    pad_y;
    logic [ScaleW-1:0]  inv_scale;
  } letterbox_regs_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic                op_i;
  logic [DstW-1:0]     dst_x_i;
  logic [DstW-1:0]     dst_y_i;
  logic [ByteW-1:0]    blue_i;
  logic [ByteW-1:0]    green_i;
  logic [ByteW-1:0]    red_i;
  logic                pad_i;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                inside_res_o;
  logic [SrcW-1:0]     src_x_o;
  logic [SrcW-1:0]     src_y_o;
  logic [IndexW-1:0]   src_index_o;
  logic [NormW-1:0]    red_norm_o;
  logic [NormW-1:0]    green_norm_o;
  logic [NormW-1:0]    blue_norm_o;

  letterbox_regs_t cur_regs;
  pixel_res_t      pending_pixels[$];
  int              mismatches  = 0;
  int              cycle_count = 0;
  // While set, neither the sender nor the receiver inserts idle cycles.
  bit              steady_flow = 1'b0;

  letterbox_nearest_resize_map dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .dst_x_i      (dst_x_i),
    .dst_y_i      (dst_y_i),
    .blue_i       (blue_i),
    .green_i      (green_i),
    .red_i        (red_i),
    .pad_i        (pad_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .inside_res_o (inside_res_o),
    .src_x_o      (src_x_o),
    .src_y_o      (src_y_o),
    .src_index_o  (src_index_o),
    .red_norm_o   (red_norm_o),
    .green_norm_o (green_norm_o),
    .blue_norm_o  (blue_norm_o)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // The receiver stalls at random unless steady flow is requested. It only
  // changes at the falling edge, so ready is stable around every rising edge.
  always @(negedge clk_i) begin
    out_ready_i <= steady_flow || ($urandom_range(99) >= IdlePercent);
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Maps one destination coordinate onto the source axis. Returns 0 when the
  // coordinate falls outside the frame or outside the scaled window. The
  // source coordinate is the floor of offset times the Q4.16 inverse scale,
  // clamped to the last screen pixel and to the largest value the output
  // field can carry. A zero screen size clamps everything to 0.
  function automatic logic nearest_src(input logic [DstW-1:0] d,
                                       input logic [PadW-1:0] pad,
                                       input logic [SizeW-1:0] size,
                                       input longint unsigned frame,
                                       input logic [ScreenW-1:0] screen,
                                       output logic [SrcW-1:0] src);
    longint unsigned dl;
    longint unsigned pl;
    longint unsigned scaled;
    longint unsigned lim;
    dl  = longint'(d);
    pl  = longint'(pad);
    src = '0;
    if (dl >= frame || dl < pl || dl - pl >= size) return 1'b0;
    scaled = ((dl - pl) * cur_regs.inv_scale) >> ScaleFrac;
    lim    = (screen == '0) ? 0 : screen - 1;
    if (lim > SrcMax) lim = SrcMax;
    if (scaled > lim) scaled = lim;
    src = scaled[SrcW-1:0];
    return 1'b1;
  endfunction

  // Works out the one result that a transfer causes. Fields that belong to
  // the other operation stay at 0, and so do all map fields outside the
  // scaled window. The index keeps only its low bits when the product wraps.
  function automatic pixel_res_t resize_pixel(input pixel_req_t req);
    pixel_res_t      res;
    logic [SrcW-1:0] sx;
    logic [SrcW-1:0] sy;
    logic            okx;
    logic            oky;
    longint unsigned idx;
    int              rb;
    int              gb;
    int              bb;
    res = '0;
    if (req.op == OP_MAP) begin
      okx = nearest_src(req.dst_x, cur_regs.pad_x, cur_regs.resized_w, FrameWidth,
                        cur_regs.screen_w, sx);
      oky = nearest_src(req.dst_y, cur_regs.pad_y, cur_regs.resized_h, FrameHeight,
                        cur_regs.screen_h, sy);
      if (okx && oky) begin
        idx            = longint'(sy) * cur_regs.screen_w + sx;
        res.inside_res = 1'b1;
        res.src_x      = sx;
        res.src_y      = sy;
        res.src_index  = idx[IndexW-1:0];
      end
    end else begin
      // Padding pixels take the fixed gray whatever bytes were fetched.
      rb = int'(req.pad ? PadValue : req.red);
      gb = int'(req.pad ? PadValue : req.green);
      bb = int'(req.pad ? PadValue : req.blue);
      res.red_norm   = NormW'(rb * NormScale);
      res.green_norm = NormW'(gb * NormScale);
      res.blue_norm  = NormW'(bb * NormScale);
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Every output transfer is matched against the oldest pending prediction.
  always @(posedge clk_i) begin
    pixel_res_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
      if (pending_pixels.size() == 0) begin
        $error("output transfer with no prediction pending");
        mismatches++;
      end else begin
        want = pending_pixels.pop_front();
        check_field("inside_res", 32'(want.inside_res), 32'(inside_res_o));
        check_field("src_x", 32'(want.src_x), 32'(src_x_o));
        check_field("src_y", 32'(want.src_y), 32'(src_y_o));
        check_field("src_index", 32'(want.src_index), 32'(src_index_o));
        check_field("red_norm", 32'(want.red_norm), 32'(red_norm_o));
        check_field("green_norm", 32'(want.green_norm), 32'(green_norm_o));
        check_field("blue_norm", 32'(want.blue_norm), 32'(blue_norm_o));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driving. Every task below starts and ends just after a falling edge with
  // nothing yet driven in that time step.
  // ---------------------------------------------------------------------------

  // Sends one transfer. Idle cycles come first unless steady flow is on; the
  // item then stays on the port until the block accepts it, and its result
  // is predicted at the edge of the transfer.
  task automatic send_pixel(input pixel_req_t req);
    while (!steady_flow && $urandom_range(99) < IdlePercent) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= req.op;
    dst_x_i    <= req.dst_x;
    dst_y_i    <= req.dst_y;
    blue_i     <= req.blue;
    green_i    <= req.green;
    red_i      <= req.red;
    pad_i      <= req.pad;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    pending_pixels.push_back(resize_pixel(req));
    @(negedge clk_i);
  endtask

  // Stops sending and waits until every predicted result has come back.
  // Each transfer causes exactly one result, so the pipeline is then empty.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Writes all registers, one per cycle, and updates our copy. Only called
  // while the block is empty.
  task automatic program_regs(input letterbox_regs_t v);
    reg_idx_e            ri;
    logic [CfgDataW-1:0] val;
    for (int i = REG_SCREEN_W; i <= REG_INV_SCALE; i++) begin
      ri = reg_idx_e'(i);
      case (ri)
        REG_SCREEN_W:  val = CfgDataW'(v.screen_w);
        REG_SCREEN_H:  val = CfgDataW'(v.screen_h);
        REG_RESIZED_W: val = CfgDataW'(v.resized_w);
        REG_RESIZED_H: val = CfgDataW'(v.resized_h);
        REG_PAD_X:     val = CfgDataW'(v.pad_x);
        REG_PAD_Y:     val = CfgDataW'(v.pad_y);
        default:       val = v.inv_scale;
      endcase
      cfg_we_i    <= 1'b1;
      cfg_index_i <= ri;
      cfg_data_i  <= val;
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
    cur_regs  = v;
  endtask

  function automatic pixel_req_t map_req(input int x, input int y);
    pixel_req_t req;
    req       = '0;
    req.op    = OP_MAP;
    req.dst_x = DstW'(x);
    req.dst_y = DstW'(y);
    return req;
  endfunction

  function automatic pixel_req_t color_req(input int b, input int g, input int r,
                                           input logic pad);
    pixel_req_t req;
    req       = '0;
    req.op    = OP_CONVERT;
    req.blue  = ByteW'(b);
    req.green = ByteW'(g);
    req.red   = ByteW'(r);
    req.pad   = pad;
    return req;
  endfunction

  function automatic letterbox_regs_t make_regs(input int sw, input int sh,
                                                input int rw, input int rh,
                                                input int px, input int py,
                                                input int scale);
    letterbox_regs_t v;
    v.screen_w  = ScreenW'(sw);
    v.screen_h  = ScreenW'(sh);
    v.resized_w = SizeW'(rw);
    v.resized_h = SizeW'(rh);
    v.pad_x     = PadW'(px);
    v.pad_y     = PadW'(py);
    v.inv_scale = ScaleW'(scale);
    return v;
  endfunction

  // Picks one destination coordinate: often inside the scaled window so that
  // the mapping path sees real work, otherwise inside the frame width or anywhere
  // the field allows, which also covers positions beyond the frame.
  function automatic logic [DstW-1:0] random_dst(input logic [PadW-1:0] pad,
                                                 input logic [SizeW-1:0] size);
    int lo;
    int hi;
    lo = int'(pad);
    hi = (size == '0) ? lo : lo + int'(size) - 1;
    if (hi > 1023) hi = 1023;
    case ($urandom_range(3))
      0:       return DstW'($urandom_range(1023));
      1:       return DstW'($urandom_range(FrameWidth - 1));
      default: return DstW'($urandom_range(hi, lo));
    endcase
  endfunction

  function automatic pixel_req_t random_pixel();
    pixel_req_t req;
    req.op    = ($urandom_range(99) < 60) ? OP_MAP : OP_CONVERT;
    req.dst_x = random_dst(cur_regs.pad_x, cur_regs.resized_w);
    req.dst_y = random_dst(cur_regs.pad_y, cur_regs.resized_h);
    req.blue  = ByteW'($urandom_range(255));
    req.green = ByteW'($urandom_range(255));
    req.red   = ByteW'($urandom_range(255));
    req.pad   = ($urandom_range(3) == 0);
    return req;
  endfunction

  // Mostly realistic setups, now and then anything the register widths hold,
  // including zero sizes and screens wider than the source fields.
  function automatic letterbox_regs_t random_regs();
    letterbox_regs_t v;
    bit wild;
    wild        = ($urandom_range(3) == 0);
    v.screen_w  = wild ? ScreenW'($urandom_range(16383)) : ScreenW'($urandom_range(8192, 1));
    v.screen_h  = wild ? ScreenW'($urandom_range(16383)) : ScreenW'($urandom_range(8192, 1));
    v.resized_w = wild ? SizeW'($urandom_range(1023)) : SizeW'($urandom_range(640, 1));
    v.resized_h = wild ? SizeW'($urandom_range(1023)) : SizeW'($urandom_range(640, 1));
    v.pad_x     = wild ? PadW'($urandom_range(511)) : PadW'($urandom_range(319));
    v.pad_y     = wild ? PadW'($urandom_range(511)) : PadW'($urandom_range(319));
    v.inv_scale = wild ? ScaleW'($urandom_range(1048575, 1))
                       : ScaleW'($urandom_range(1 << 18, 1 << 14));
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset setup: a 1920x1080 screen scaled by 3 into a 640x360 window that
  // sits 140 rows down. Nothing is written, so the reset values are checked.
  task automatic test_reset_setup();
    cur_regs = make_regs(ScreenWRst, ScreenHRst, ResizedWRst, ResizedHRst,
                         PadXRst, PadYRst, InvScaleRst);
    send_pixel(map_req(0, 140));       // first pixel of the window
    send_pixel(map_req(639, 499));     // last pixel of the window
    send_pixel(map_req(0, 139));       // top padding band
    send_pixel(map_req(0, 500));       // bottom padding band
    send_pixel(map_req(1023, 1023));   // beyond the frame
    send_pixel(map_req(512, 320));
    send_pixel(color_req(0, 0, 0, 1'b0));
    send_pixel(color_req(255, 255, 255, 1'b0));
    send_pixel(color_req(8'hAA, 8'h55, 8'h0F, 1'b0));
    send_pixel(color_req(255, 0, 255, 1'b1)); // padding ignores the bytes
    settle();
  endtask

  // Corner setups: zero screen, screens wider than the source fields with an
  // index that wraps, a window that runs past the frame, a one pixel window.
  task automatic test_register_corners();
    program_regs(make_regs(0, 0, 640, 640, 0, 0, 1048575));
    send_pixel(map_req(639, 639));
    send_pixel(map_req(1, 1));
    settle();

    program_regs(make_regs(16383, 16383, 640, 640, 0, 0, 1048575));
    send_pixel(map_req(639, 639));
    send_pixel(map_req(0, 0));
    send_pixel(map_req(1, 1));
    settle();

    program_regs(make_regs(8192, 8192, 640, 640, 319, 319, 1));
    send_pixel(map_req(639, 639));
    send_pixel(map_req(640, 319));     // window extends, frame does not
    send_pixel(map_req(318, 400));
    send_pixel(map_req(319, 319));
    settle();

    program_regs(make_regs(1, 1, 1, 1, 100, 200, 65536));
    send_pixel(map_req(100, 200));
    send_pixel(map_req(101, 200));
    send_pixel(map_req(100, 199));
    settle();
  endtask

  // Random traffic over several random setups. One phase runs without any
  // idling, and in another the sender stops halfway until the pipeline has
  // drained before it carries on.
  task automatic test_random_traffic();
    for (int phase = 0; phase < RandPhases; phase++) begin
      program_regs(random_regs());
      steady_flow = (phase == 2);
      for (int n = 0; n < PhaseItems; n++) begin
        if (phase == 3 && n == PhaseItems / 2) settle();
        send_pixel(random_pixel());
      end
      settle();
      steady_flow = 1'b0;
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = REG_SCREEN_W;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    op_i        = OP_MAP;
    dst_x_i     = '0;
    dst_y_i     = '0;
    blue_i      = '0;
    green_i     = '0;
    red_i       = '0;
    pad_i       = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_setup();
    test_register_corners();
    test_random_traffic();

    // Leave room for any stray output transfer after the last result.
    settle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/lbnr_pkg.sv
hw/rtl/letterbox_nearest_resize_map.sv
hw/rtl/lbnr_checker.sv
bench/testbench.sv
